// ===== rtl/core/ppgb_pkg.sv =====
package ppgb_pkg;

  // Grid and counter geometry; grid sizes are powers of two so that the
  // modulo-grid reduction is a mask
  localparam int unsigned GRID_X     = 64;
  localparam int unsigned GRID_Y     = 64;
  localparam int unsigned COUNT_BITS = 16;

  localparam int unsigned NCELLS = GRID_X * GRID_Y;
  localparam int unsigned CELL_W = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int unsigned GX_W   = (GRID_X > 1) ? $clog2(GRID_X) : 1;
  localparam int unsigned GY_W   = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
  localparam int unsigned GMAX   = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
  localparam int unsigned GBITS  = $clog2(GMAX + 1);

  // Mean divider: 48 bit dividend, divisor holds a total count
  localparam int unsigned DIVD_W = 48;
  localparam int unsigned DIV_W  = (COUNT_BITS + 1 > GBITS) ? COUNT_BITS + 1 : GBITS;
  localparam int unsigned DCNT_W = $clog2(DIVD_W);

  // Shared multiplier
  localparam int unsigned MUL_A_W = (COUNT_BITS + 1 > 32) ? COUNT_BITS + 1 : 32;
  localparam int unsigned PROD_W  = MUL_A_W + 32;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 32;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_X = 3'd0,
    CFG_BOX_Y = 3'd1,
    CFG_INV_X = 3'd2,
    CFG_INV_Y = 3'd3,
    CFG_BAND  = 3'd4,
    CFG_ICA   = 3'd5,
    CFG_EMPTY = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [COUNT_BITS-1:0] green;
    logic [COUNT_BITS-1:0] red;
    logic signed [47:0]    sum;
  } cell_t;

  typedef enum logic [4:0] {
    DP_IDLE,
    DP_LATCH,
    DP_CLR,
    DP_MAG,
    DP_NMUL,
    DP_WRAP,
    DP_SMUL,
    DP_SCALE,
    DP_QUOT,
    DP_WAIT,
    DP_COORD,
    DP_RMWRD,
    DP_RMWWR,
    DP_RDADDR,
    DP_RDMEM,
    DP_MDIV,
    DP_DENSG,
    DP_DENSR,
    DP_DENST,
    DP_OUT
  } dp_step_e;

  typedef struct packed {
    dp_step_e step;
    logic     axis_y;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic clr_last;
    logic div_done;
  } dp_stat_t;

endpackage

// ===== rtl/core/ppgb_div.sv =====
module ppgb_div import ppgb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [DIVD_W-1:0] quot_o
);

  logic              run_q, done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DIVD_W-1:0] quot_q;
  logic [DIV_W-1:0]  rem_q, dsr_q;
  logic [DIV_W:0]    trial;
  logic              fits;

  // One quotient bit a cycle, restoring
  assign trial = {rem_q, quot_q[DIVD_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DCNT_W'(DIVD_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dsr_q  <= divisor_i;
    end else if (run_q) begin
      quot_q <= {quot_q[DIVD_W-2:0], fits};
      rem_q  <= fits ? DIV_W'(trial - {1'b0, dsr_q}) : DIV_W'(trial);
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/core/ppgb_dp.sv =====
module ppgb_dp import ppgb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  output dp_stat_t             stat_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic [1:0]           operation_i,
  input  logic signed [31:0]   pos_x_i,
  input  logic signed [31:0]   pos_y_i,
  input  logic signed [31:0]   start_y_i,
  input  logic [11:0]          read_cell_i,
  output logic [47:0]          green_density_o,
  output logic [47:0]          red_density_o,
  output logic [47:0]          total_density_o,
  output logic signed [31:0]   mean_start_y_o,
  output logic                 cell_empty_o
);

  // Configuration
  logic [30:0] box_x_q, box_y_q, band_q;
  logic [31:0] inv_x_q, inv_y_q, ica_q;
  logic [31:0] empty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_x_q <= 31'd65536;
      box_y_q <= 31'd65536;
      inv_x_q <= 32'hFFFF_FFFF;
      inv_y_q <= 32'hFFFF_FFFF;
      band_q  <= 31'd10923;
      ica_q   <= 32'd65536;
      empty_q <= 32'hFFFF_8000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BOX_X: box_x_q <= cfg_wdata_i[30:0];
        CFG_BOX_Y: box_y_q <= cfg_wdata_i[30:0];
        CFG_INV_X: inv_x_q <= cfg_wdata_i;
        CFG_INV_Y: inv_y_q <= cfg_wdata_i;
        CFG_BAND:  band_q  <= cfg_wdata_i[30:0];
        CFG_ICA:   ica_q   <= cfg_wdata_i;
        CFG_EMPTY: empty_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Latched item
  op_e                op_q;
  logic signed [31:0] px_q, py_q, sy_q;
  logic [11:0]        rc_q;

  // Working registers
  logic [PROD_W-1:0]       prod_q;
  logic signed [31:0]      w_q;
  logic signed [63:0]      v_q;
  logic [31:0]             qmag_q;
  logic                    qneg_q;
  logic [GX_W-1:0]         jx_q;
  logic [GY_W-1:0]         jy_q;
  logic [CELL_W-1:0]       cell_q, clr_cnt_q;
  logic                    inr_q;
  logic [COUNT_BITS-1:0]   g_q, r_q;
  logic [COUNT_BITS:0]     t_q;
  logic signed [47:0]      sum_q;
  logic [47:0]             gden_q, rden_q, tden_q;
  logic signed [31:0]      mean_q;
  logic                    empty_flag_q;

  // Memory
  cell_t             mem [NCELLS];
  cell_t             rd_q, wdata;
  logic              we;
  logic [CELL_W-1:0] waddr, raddr;

  // Axis selection
  logic signed [31:0] p_sel;
  logic [30:0]        len_sel;
  logic [31:0]        inv_sel;
  logic [DIV_W-1:0]   g_sel;
  logic signed [63:0] g64;

  assign p_sel   = cmd_i.axis_y ? py_q    : px_q;
  assign len_sel = cmd_i.axis_y ? box_y_q : box_x_q;
  assign inv_sel = cmd_i.axis_y ? inv_y_q : inv_x_q;
  assign g_sel   = cmd_i.axis_y ? DIV_W'(GRID_Y) : DIV_W'(GRID_X);
  assign g64     = cmd_i.axis_y ? 64'(GRID_Y) : 64'(GRID_X);

  // Combinational helpers
  logic [31:0]        p_mag, w_mag;
  logic [64:0]        n_sum;
  logic [16:0]        n_mag;
  logic signed [49:0] p50, nl50, w50;
  logic signed [48:0] s49;
  logic signed [63:0] s64, v_d;
  logic [63:0]        v_mag;
  logic [DIV_W-1:0]   crem;
  logic [DIV_W-1:0]   coord;
  logic [MUL_A_W-1:0] mul_a;
  logic [31:0]        mul_b;
  logic [PROD_W-1:0]  prod_d;
  logic [47:0]        dens;
  logic               div_start, div_done;
  logic [DIVD_W-1:0]  div_dvd, quot;
  logic [DIV_W-1:0]   div_dsr;
  logic signed [32:0] sy33, b33;
  logic               is_red;
  logic [COUNT_BITS-1:0] cnt_sel;
  logic signed [48:0] sum49;
  logic signed [47:0] sum_sat;
  logic [47:0]        sum_mag, mean48;
  logic [12:0]        rc_ext;

  always_comb begin
    p_mag  = p_sel[31] ? (~p_sel + 32'd1) : p_sel;
    w_mag  = w_q[31] ? (~w_q + 32'd1) : w_q;
    n_sum  = 65'(prod_q[63:0]) + (65'd1 << 47);
    n_mag  = n_sum[64:48];
    p50    = 50'(p_sel);
    nl50   = $signed({2'b00, prod_q[47:0]});
    w50    = p_sel[31] ? (p50 + nl50) : (p50 - nl50);
    s49    = $signed({1'b0, prod_q[63:16]});
    if (w_q[31]) s49 = -s49;
    s64    = 64'(s49);
    v_d    = (cmd_i.axis_y ? s64 * $signed(64'(GRID_Y)) : s64 * $signed(64'(GRID_X)))
           + (g64 <<< 31);
    v_mag  = v_q[63] ? 64'(-v_q) : 64'(v_q);
    // Remainder by a power-of-two grid size, then fold negatives upward
    crem   = cmd_i.axis_y ? DIV_W'(qmag_q % GRID_Y) : DIV_W'(qmag_q % GRID_X);
    coord  = (qneg_q && (crem != '0)) ? (g_sel - crem) : crem;
    dens   = (prod_q[PROD_W-1:48] != '0) ? '1 : prod_q[47:0];
  end

  // Shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.step)
      DP_MAG:   begin mul_a = MUL_A_W'(p_mag);  mul_b = inv_sel; end
      DP_NMUL:  begin mul_a = MUL_A_W'(n_mag);  mul_b = {1'b0, len_sel}; end
      DP_SMUL:  begin mul_a = MUL_A_W'(w_mag);  mul_b = inv_sel; end
      DP_DENSG: begin mul_a = MUL_A_W'(g_q);    mul_b = ica_q; end
      DP_DENSR: begin mul_a = MUL_A_W'(r_q);    mul_b = ica_q; end
      DP_DENST: begin mul_a = MUL_A_W'(t_q);    mul_b = ica_q; end
      default: ;
    endcase
    prod_d = mul_a * mul_b;
  end

  // Divider operands: mean of the cell
  assign sum_mag   = sum_q[47] ? 48'(-sum_q) : 48'(sum_q);
  assign div_start = (cmd_i.step == DP_MDIV);
  assign div_dvd   = sum_mag;
  assign div_dsr   = DIV_W'(t_q);
  assign mean48    = sum_q[47] ? (~quot + 48'd1) : quot;

  ppgb_div u_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Add update
  always_comb begin
    sy33    = 33'(sy_q);
    b33     = $signed({2'b00, band_q});
    is_red  = (sy33 < -b33) || (sy33 > b33);
    cnt_sel = is_red ? rd_q.red : rd_q.green;
    sum49   = 49'(rd_q.sum) + 49'(sy_q);
    if (sum49 > 49'sh7FFF_FFFF_FFFF)       sum_sat = 48'sh7FFF_FFFF_FFFF;
    else if (sum49 < -49'sh8000_0000_0000) sum_sat = 48'sh8000_0000_0000;
    else                                   sum_sat = 48'(sum49);
  end

  always_comb begin
    we    = 1'b0;
    waddr = cell_q;
    wdata = rd_q;
    raddr = cell_q;
    case (cmd_i.step)
      DP_CLR: begin
        we    = 1'b1;
        waddr = clr_cnt_q;
        wdata = '0;
      end
      DP_RMWRD:  raddr = CELL_W'(32'(jx_q) + 32'(jy_q) * GRID_X);
      DP_RDADDR: raddr = rc_q[CELL_W-1:0];
      DP_RMWWR: begin
        we = (cnt_sel != CNT_MAX);
        if (is_red) wdata.red = rd_q.red + 1'b1;
        else        wdata.green = rd_q.green + 1'b1;
        wdata.sum = sum_sat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  // Clearing sweep
  assign stat_o.clr_last = (clr_cnt_q == CELL_W'(NCELLS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.step == DP_CLR) begin
      clr_cnt_q <= stat_o.clr_last ? '0 : clr_cnt_q + 1'b1;
    end
  end

  assign rc_ext = {1'b0, rc_q};

  always_ff @(posedge clk_i) begin
    case (cmd_i.step)
      DP_LATCH: begin
        op_q <= op_e'(operation_i);
        px_q <= pos_x_i;
        py_q <= pos_y_i;
        sy_q <= start_y_i;
        rc_q <= read_cell_i;
      end
      DP_MAG, DP_NMUL, DP_SMUL, DP_DENSG: prod_q <= prod_d;
      DP_WRAP: begin
        if (w50 > 50'sh7FFF_FFFF)       w_q <= 32'sh7FFF_FFFF;
        else if (w50 < -50'sh8000_0000) w_q <= 32'sh8000_0000;
        else                            w_q <= 32'(w50);
      end
      DP_SCALE: v_q <= v_d;
      DP_QUOT: begin
        qmag_q <= v_mag[63:32];
        qneg_q <= v_q[63];
      end
      DP_COORD: begin
        if (cmd_i.axis_y) jy_q <= GY_W'(coord);
        else              jx_q <= GX_W'(coord);
      end
      DP_RMWRD: cell_q <= CELL_W'(32'(jx_q) + 32'(jy_q) * GRID_X);
      DP_RDADDR: inr_q <= (rc_ext < 13'(NCELLS));
      DP_RDMEM: begin
        g_q   <= inr_q ? rd_q.green : '0;
        r_q   <= inr_q ? rd_q.red   : '0;
        t_q   <= inr_q ? ({1'b0, rd_q.green} + {1'b0, rd_q.red}) : '0;
        sum_q <= inr_q ? rd_q.sum : '0;
      end
      DP_DENSR: begin
        gden_q <= dens;
        prod_q <= prod_d;
      end
      DP_DENST: begin
        rden_q <= dens;
        prod_q <= prod_d;
      end
      DP_OUT: begin
        tden_q       <= dens;
        empty_flag_q <= (t_q == '0);
        mean_q       <= (t_q == '0) ? $signed(empty_q) : $signed(mean48[31:0]);
      end
      default: ;
    endcase
  end

  assign stat_o.op       = op_q;
  assign stat_o.div_done = div_done;

  assign green_density_o = gden_q;
  assign red_density_o   = rden_q;
  assign total_density_o = tden_q;
  assign mean_start_y_o  = mean_q;
  assign cell_empty_o    = empty_flag_q;

endmodule

// ===== rtl/core/ppgb_ctrl.sv =====
module ppgb_ctrl import ppgb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  output logic     done_o,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_DISP,
    ST_MAG, ST_NMUL, ST_WRAP, ST_SMUL, ST_SCALE, ST_QUOT,
    ST_COORD, ST_RMWRD, ST_RMWWR,
    ST_RDADDR, ST_RDMEM, ST_MDIV, ST_MWAIT,
    ST_DENSG, ST_DENSR, ST_DENST, ST_OUT
  } state_e;

  state_e state_q;
  logic   axis_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      axis_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == ST_OUT);
      unique case (state_q)
        ST_CLR:   if (stat_i.clr_last) state_q <= ST_IDLE;
        ST_IDLE:  if (start_i) state_q <= ST_DISP;
        ST_DISP: begin
          axis_q <= 1'b0;
          unique case (stat_i.op)
            OP_CLEAR: state_q <= ST_CLR;
            OP_ADD:   state_q <= ST_MAG;
            OP_READ:  state_q <= ST_RDADDR;
            default:  state_q <= ST_IDLE;
          endcase
        end
        ST_MAG:   state_q <= ST_NMUL;
        ST_NMUL:  state_q <= ST_WRAP;
        ST_WRAP:  state_q <= ST_SMUL;
        ST_SMUL:  state_q <= ST_SCALE;
        ST_SCALE: state_q <= ST_QUOT;
        ST_QUOT:  state_q <= ST_COORD;
        ST_COORD: begin
          if (axis_q) begin
            state_q <= ST_RMWRD;
          end else begin
            axis_q  <= 1'b1;
            state_q <= ST_MAG;
          end
        end
        ST_RMWRD:  state_q <= ST_RMWWR;
        ST_RMWWR:  state_q <= ST_IDLE;
        ST_RDADDR: state_q <= ST_RDMEM;
        ST_RDMEM:  state_q <= ST_MDIV;
        ST_MDIV:   state_q <= ST_MWAIT;
        ST_MWAIT:  if (stat_i.div_done) state_q <= ST_DENSG;
        ST_DENSG:  state_q <= ST_DENSR;
        ST_DENSR:  state_q <= ST_DENST;
        ST_DENST:  state_q <= ST_OUT;
        ST_OUT:    state_q <= ST_IDLE;
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o.axis_y = axis_q;
    unique case (state_q)
      ST_CLR:    cmd_o.step = DP_CLR;
      ST_IDLE:   cmd_o.step = start_i ? DP_LATCH : DP_IDLE;
      ST_MAG:    cmd_o.step = DP_MAG;
      ST_NMUL:   cmd_o.step = DP_NMUL;
      ST_WRAP:   cmd_o.step = DP_WRAP;
      ST_SMUL:   cmd_o.step = DP_SMUL;
      ST_SCALE:  cmd_o.step = DP_SCALE;
      ST_QUOT:   cmd_o.step = DP_QUOT;
      ST_COORD:  cmd_o.step = DP_COORD;
      ST_RMWRD:  cmd_o.step = DP_RMWRD;
      ST_RMWWR:  cmd_o.step = DP_RMWWR;
      ST_RDADDR: cmd_o.step = DP_RDADDR;
      ST_RDMEM:  cmd_o.step = DP_RDMEM;
      ST_MDIV:   cmd_o.step = DP_MDIV;
      ST_DENSG:  cmd_o.step = DP_DENSG;
      ST_DENSR:  cmd_o.step = DP_DENSR;
      ST_DENST:  cmd_o.step = DP_DENST;
      ST_OUT:    cmd_o.step = DP_OUT;
      ST_MWAIT:  cmd_o.step = DP_WAIT;
      default:   cmd_o.step = DP_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

// ===== rtl/core/periodic_particle_grid_binning_unit.sv =====
// Periodic particle grid binning. Pulse start while busy is low to issue one
// command: clear, add a particle or read a cell. The unit handles one command
// at a time and holds busy high until it is finished. A read result appears
// on the result ports for a single cycle with done_o high; the receiver must
// take it then, as the unit cannot be stalled. Clear and add give no result.
// Steps from the start transfer: a clear decodes the command, then sweeps
// every cell (GRID_X * GRID_Y, 4096 by default) to zero; an add decodes,
// then runs the image fold and the grid mapping for each axis in turn and
// ends with the read-modify-write of the cell; a read decodes, reads the
// cell, waits on the one-bit-per-cycle 48 bit divider that forms the mean,
// scales the densities, and its result sits on the ports in the cycle in
// which busy has just dropped. After reset the unit sweeps the cell memory
// to zero, one cell per cycle, and holds busy high until the sweep is done;
// configuration writes are taken at any time but should only be made while
// the unit is idle.
module periodic_particle_grid_binning_unit import ppgb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Command transfer
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           operation_i,
  input  logic signed [31:0]   pos_x_i,
  input  logic signed [31:0]   pos_y_i,
  input  logic signed [31:0]   start_y_i,
  input  logic [11:0]          read_cell_i,
  // Configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // Result transfer
  output logic                 done_o,
  output logic [47:0]          green_density_o,
  output logic [47:0]          red_density_o,
  output logic [47:0]          total_density_o,
  output logic signed [31:0]   mean_start_y_o,
  output logic                 cell_empty_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence the steps of each command
  ppgb_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i (start),
    .busy_o  (busy),
    .done_o,
    .cmd_o   (cmd),
    .stat_i  (stat)
  );

  // Hold configuration, cell memory, multiplier and divider
  ppgb_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .operation_i,
    .pos_x_i,
    .pos_y_i,
    .start_y_i,
    .read_cell_i,
    .green_density_o,
    .red_density_o,
    .total_density_o,
    .mean_start_y_o,
    .cell_empty_o
  );

endmodule

// ===== verif/tb_periodic_particle_grid_binning_unit.sv =====
module tb_periodic_particle_grid_binning_unit;
  import ppgb_pkg::*;

  localparam longint unsigned DENS_LIMIT = 64'hFFFF_FFFF_FFFF;
  localparam longint          SUM_HI     = 64'sh7FFF_FFFF_FFFF;
  localparam longint          SUM_LO     = -64'sh8000_0000_0000;

  typedef struct {
    logic [47:0]        green_density;
    logic [47:0]        red_density;
    logic [47:0]        total_density;
    logic signed [31:0] mean_start_y;
    logic               cell_empty;
  } cell_report_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         operation_i;
  logic signed [31:0] pos_x_i;
  logic signed [31:0] pos_y_i;
  logic signed [31:0] start_y_i;
  logic [11:0]        read_cell_i;
  logic               cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]   cfg_wdata_i;
  logic               done_o;
  logic [47:0]        green_density_o;
  logic [47:0]        red_density_o;
  logic [47:0]        total_density_o;
  logic signed [31:0] mean_start_y_o;
  logic               cell_empty_o;

  periodic_particle_grid_binning_unit dut (.*);

  // Local copy of the block's configuration and cell store
  logic [30:0] box_x, box_y, half_band;
  logic [31:0] inv_x, inv_y, inv_area;
  logic signed [31:0] empty_mark;
  int unsigned green_cnt [NCELLS];
  int unsigned red_cnt   [NCELLS];
  longint      y_sum     [NCELLS];

  cell_report_t pending_reports[$];
  int           touched_cells[$];
  int           fail_count = 0;

  // Clock: period of 10 units
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Timeout guard: far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("tb_periodic_particle_grid_binning_unit NOT OK");
    $finish;
  end

  // Fold a coordinate into the periodic box and return its grid index
  function automatic int fold_to_cell(longint p, longint len, longint unsigned inv, int g);
    longint unsigned mag;
    longint          n, w, s, v, q, r;
    mag = (p < 0) ? longint'(-p) : p;
    n = longint'((mag * inv + 64'h8000_0000_0000) >> 48);
    if (p < 0) n = -n;
    w = p - n * len;
    if (w > 64'sd2147483647) w = 64'sd2147483647;
    if (w < -64'sd2147483648) w = -64'sd2147483648;
    mag = (w < 0) ? longint'(-w) : w;
    s = longint'((mag * inv) >> 16);
    if (w < 0) s = -s;
    v = s * g + (longint'(g) <<< 31);
    q = (v >= 0) ? (v >>> 32) : -longint'(longint'(-v) >>> 32);
    r = q % g;
    if (r < 0) r += g;
    return int'(r);
  endfunction

  function automatic logic [47:0] scale_density(longint unsigned count);
    if (inv_area != 0 && count > DENS_LIMIT / inv_area) return DENS_LIMIT[47:0];
    return 48'(count * inv_area);
  endfunction

  function automatic void clear_cells();
    foreach (green_cnt[i]) begin
      green_cnt[i] = 0;
      red_cnt[i]   = 0;
      y_sum[i]     = 0;
    end
    touched_cells.delete();
  endfunction

  // Update the cell store for one accepted command; queue a report on a read
  function automatic void apply_command(op_e op, logic signed [31:0] px, logic signed [31:0] py,
                                        logic signed [31:0] sy, logic [11:0] cell_idx);
    int           hit_idx;
    bit           is_red;
    longint       sum;
    longint unsigned tot;
    cell_report_t rep;
    case (op)
      OP_CLEAR: clear_cells();
      OP_ADD: begin
        hit_idx = fold_to_cell(px, box_x, inv_x, GRID_X)
                + fold_to_cell(py, box_y, inv_y, GRID_Y) * GRID_X;
        is_red = (longint'(sy) < -longint'(half_band)) || (longint'(sy) > longint'(half_band));
        touched_cells.push_back(hit_idx);
        // a saturated colour count drops the whole add
        if ((is_red ? red_cnt[hit_idx] : green_cnt[hit_idx]) < CNT_MAX) begin
          if (is_red) red_cnt[hit_idx]++;
          else green_cnt[hit_idx]++;
          sum = y_sum[hit_idx] + sy;
          if (sum > SUM_HI) sum = SUM_HI;
          if (sum < SUM_LO) sum = SUM_LO;
          y_sum[hit_idx] = sum;
        end
      end
      OP_READ: begin
        tot = green_cnt[cell_idx] + red_cnt[cell_idx];
        rep.green_density = scale_density(green_cnt[cell_idx]);
        rep.red_density   = scale_density(red_cnt[cell_idx]);
        rep.total_density = scale_density(tot);
        if (tot == 0) begin
          rep.mean_start_y = empty_mark;
          rep.cell_empty   = 1'b1;
        end else begin
          rep.mean_start_y = 32'(y_sum[cell_idx] / longint'(tot));
          rep.cell_empty   = 1'b0;
        end
        pending_reports.push_back(rep);
      end
      default: ;
    endcase
  endfunction

  // Drive one command and hold it until the unit takes the transfer
  task automatic issue(op_e op, logic signed [31:0] px, logic signed [31:0] py,
                       logic signed [31:0] sy, logic [11:0] cell_idx);
    @(negedge clk_i);
    start       <= 1'b1;
    operation_i <= op;
    pos_x_i     <= px;
    pos_y_i     <= py;
    start_y_i   <= sy;
    read_cell_i <= cell_idx;
    do @(posedge clk_i); while (busy);
    apply_command(op, px, py, sy, cell_idx);
  endtask

  task automatic pause(int cycles);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Drop start and wait until the unit is idle with no report outstanding
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    do @(posedge clk_i); while (busy || pending_reports.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BOX_X: box_x      = val[30:0];
      CFG_BOX_Y: box_y      = val[30:0];
      CFG_INV_X: inv_x      = val;
      CFG_INV_Y: inv_y      = val;
      CFG_BAND:  half_band  = val[30:0];
      CFG_ICA:   inv_area   = val;
      CFG_EMPTY: empty_mark = val;
      default: ;
    endcase
  endtask

  task automatic load_config(logic [31:0] bx, logic [31:0] by, logic [31:0] ix,
                             logic [31:0] iy, logic [31:0] band, logic [31:0] ica,
                             logic [31:0] emp);
    settle();
    write_reg(CFG_BOX_X, bx);
    write_reg(CFG_BOX_Y, by);
    write_reg(CFG_INV_X, ix);
    write_reg(CFG_INV_Y, iy);
    write_reg(CFG_BAND, band);
    write_reg(CFG_ICA, ica);
    write_reg(CFG_EMPTY, emp);
  endtask

  // Compare each report against the oldest expectation
  always @(posedge clk_i) begin
    cell_report_t exp_rep;
    if (rst_ni && done_o) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected report");
        fail_count++;
      end else begin
        exp_rep = pending_reports.pop_front();
        if (green_density_o !== exp_rep.green_density) begin
          $error("green_density exp %h got %h", exp_rep.green_density, green_density_o);
          fail_count++;
        end
        if (red_density_o !== exp_rep.red_density) begin
          $error("red_density exp %h got %h", exp_rep.red_density, red_density_o);
          fail_count++;
        end
        if (total_density_o !== exp_rep.total_density) begin
          $error("total_density exp %h got %h", exp_rep.total_density, total_density_o);
          fail_count++;
        end
        if (mean_start_y_o !== exp_rep.mean_start_y) begin
          $error("mean_start_y exp %h got %h", exp_rep.mean_start_y, mean_start_y_o);
          fail_count++;
        end
        if (cell_empty_o !== exp_rep.cell_empty) begin
          $error("cell_empty exp %b got %b", exp_rep.cell_empty, cell_empty_o);
          fail_count++;
        end
      end
    end
  end

  // Empty cells after the reset sweep, at both ends of the index range
  task automatic test_reset_state();
    issue(OP_READ, 0, 0, 0, 12'd0);
    issue(OP_READ, 0, 0, 0, 12'hFFF);
  endtask

  // Band edges, position extremes, then read back what was hit
  task automatic test_directed_adds();
    logic signed [31:0] b;
    b = signed'({1'b0, half_band});
    issue(OP_ADD, 0, 0, b, 0);
    issue(OP_ADD, 0, 0, b + 1, 0);
    issue(OP_ADD, 0, 0, -b, 0);
    issue(OP_ADD, 0, 0, -b - 1, 0);
    issue(OP_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
    issue(OP_ADD, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
    issue(OP_ADD, 32'sh0000_8000, -32'sh0000_8000, 0, 0);
    issue(OP_ADD, -32'sh0000_8000, 32'sh0000_8000, 0, 0);
    foreach (touched_cells[i]) issue(OP_READ, 0, 0, 0, 12'(touched_cells[i]));
  endtask

  // Clear empties touched cells; the unused code changes nothing
  task automatic test_clear_and_unused();
    int c;
    c = touched_cells[0];
    issue(OP_NONE, $urandom, $urandom, $urandom, 12'($urandom));
    issue(OP_READ, 0, 0, 0, 12'(c));
    issue(OP_CLEAR, 0, 0, 0, 0);
    issue(OP_READ, 0, 0, 0, 12'(c));
  endtask

  // Random commands, in bursts if with_gaps; mostly adds, reads often of cells hit
  task automatic test_random_traffic(int n_items, bit with_gaps);
    int burst_left;
    int sel;
    logic signed [31:0] px, py, sy;
    logic [11:0] idx;
    burst_left = $urandom_range(1, 8);
    issue(OP_CLEAR, 0, 0, 0, 0);
    repeat (n_items) begin
      sel = $urandom_range(0, 99);
      if ($urandom_range(0, 2) == 0) begin
        px = 32'($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
        py = 32'($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
      end else begin
        px = $urandom;
        py = $urandom;
      end
      sy = ($urandom_range(0, 1)) ? $urandom
                                  : 32'($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
      if (touched_cells.size() != 0 && $urandom_range(0, 1))
        idx = 12'(touched_cells[$urandom_range(0, touched_cells.size() - 1)]);
      else
        idx = 12'($urandom);
      if (sel < 60) issue(OP_ADD, px, py, sy, idx);
      else if (sel < 97) issue(OP_READ, px, py, sy, idx);
      else issue(OP_NONE, px, py, sy, idx);
      if (with_gaps) begin
        burst_left = burst_left - 1;
        if (burst_left == 0) begin
          pause($urandom_range(1, 6));
          burst_left = $urandom_range(1, 8);
        end
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    operation_i = OP_NONE;
    pos_x_i     = '0;
    pos_y_i     = '0;
    start_y_i   = '0;
    read_cell_i = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_BOX_X;
    cfg_wdata_i = '0;
    box_x = 31'd65536; box_y = 31'd65536;
    inv_x = '1; inv_y = '1;
    half_band = 31'd10923; inv_area = 32'd65536; empty_mark = -32'sd32768;
    clear_cells();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_directed_adds();
    test_clear_and_unused();

    // Reset settings, then a 64-unit box, the upper and lower extremes, and random
    test_random_traffic(400, 1'b1);
    load_config(32'h0040_0000, 32'h0040_0000, 32'h0400_0000, 32'h0400_0000,
                32'h0020_0000, 32'h0001_0000, $urandom);
    test_random_traffic(400, 1'b0);
    load_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    test_random_traffic(400, 1'b1);
    load_config(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000);
    test_random_traffic(300, 1'b1);
    load_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    test_random_traffic(500, 1'b1);

    settle();
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_periodic_particle_grid_binning_unit OK");
    end else begin
      $display("tb_periodic_particle_grid_binning_unit NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ppgb_pkg.sv
rtl/core/ppgb_div.sv
rtl/core/ppgb_dp.sv
rtl/core/ppgb_ctrl.sv
rtl/core/periodic_particle_grid_binning_unit.sv
verif/tb_periodic_particle_grid_binning_unit.sv
